/* hdl/toy_cpu_execute_unit_top_assert.svh */
// Assertion shorthands for the toy CPU execute unit.
// Both forms sample on the rising edge of clk and are off while rst is high.
`ifndef TOY_CPU_EXECUTE_UNIT_TOP_ASSERT_SVH
`define TOY_CPU_EXECUTE_UNIT_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCEU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCEU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/tceu_pkg.sv */
package tceu_pkg;

  // Commands.
  localparam logic [1:0] CMD_EXEC     = 2'd0;
  localparam logic [1:0] CMD_READ_REG = 2'd1;
  localparam logic [1:0] CMD_READ_MEM = 2'd2;

  // Opcodes.
  localparam logic [3:0] OP_LOAD  = 4'd0;
  localparam logic [3:0] OP_LOADM = 4'd1;
  localparam logic [3:0] OP_ADD   = 4'd2;
  localparam logic [3:0] OP_ADDI  = 4'd3;
  localparam logic [3:0] OP_SUB   = 4'd4;
  localparam logic [3:0] OP_SUBI  = 4'd5;
  localparam logic [3:0] OP_STORE = 4'd6;
  localparam logic [3:0] OP_MOV   = 4'd7;
  localparam logic [3:0] OP_JMP   = 4'd8;
  localparam logic [3:0] OP_BEQ   = 4'd9;
  localparam logic [3:0] OP_BNE   = 4'd10;
  localparam logic [3:0] OP_HALT  = 4'd11;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_HALTED  = 2'd3;

  // Cycle weights for the weighted cycle counter.
  localparam logic [31:0] CYC_MEM    = 32'd2;
  localparam logic [31:0] CYC_BRANCH = 32'd3;
  localparam logic [31:0] CYC_OTHER  = 32'd1;

  typedef struct packed {
    logic [1:0]         command;
    logic [3:0]         opcode;
    logic signed [31:0] arg_a;
    logic signed [31:0] arg_b;
    logic signed [31:0] arg_c;
  } req_t;

  typedef struct packed {
    logic [15:0]        next_pc;
    logic               halted;
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [31:0]        instructions_executed;
    logic [31:0]        cycle_total;
    logic [31:0]        alu_count;
    logic [31:0]        memory_count;
    logic [31:0]        branch_count;
    logic [31:0]        taken_count;
  } rsp_t;

endpackage

/* hdl/toy_cpu_execute_unit_top.sv */
// Toy CPU execute unit: runs one already-fetched instruction, or answers one register or
// memory-word query, per beat, and returns one result beat per request carrying the next
// program counter, the halt flag, a status code, the queried word and six performance
// counters. The register file and the data memory are synchronous RAMs with registered
// read data; a request reads its operands as it is accepted, and the execute stage then
// computes, writes back and fills the output register, with results from the item ahead
// forwarded into the read data. Sustained rate is one request per cycle while rsp_stall
// is low; a result beat passes through the execute stage register and the output register
// before it is valid. After reset the data memory is zeroed by a clearing pass, one word
// a cycle, while req_stall is held high.
module toy_cpu_execute_unit_top #(
  parameter int NUM_REGS  = 4,
  parameter int MEM_WORDS = 256,
  parameter int PC_BITS   = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  tceu_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output tceu_pkg::rsp_t  rsp
);

  localparam int REG_AW = $clog2(NUM_REGS);
  localparam int MEM_AW = $clog2(MEM_WORDS);

  // Storage.
  logic [31:0] rf [NUM_REGS];
  logic [NUM_REGS-1:0] rf_vld;
  logic [31:0] dmem [MEM_WORDS];

  // Clearing pass.
  logic clr_active;
  logic [MEM_AW-1:0] clr_addr;

  // Architectural state outside the RAMs.
  logic [PC_BITS-1:0] pc;
  logic halt;
  logic [31:0] cnt_insn, cnt_cycle, cnt_alu, cnt_mem, cnt_br, cnt_taken;

  // Execute stage registers.
  logic s1_valid;
  tceu_pkg::req_t s1;
  logic [31:0] rd1_q, rd2_q, mrd_q;
  logic rd1_vld, rd2_vld;
  logic fwd1, fwd2, mfwd;
  logic [31:0] rf_fwd_d, mem_fwd_d;

  logic in_acc, adv1;

  // Read addresses at accept.
  logic is_rrr;
  logic [REG_AW-1:0] ra1, ra2;
  logic [MEM_AW-1:0] mra;
  logic [31:0] in_a, in_b, in_c;

  // Stage one results.
  logic rf_we;
  logic [REG_AW-1:0] rf_wa;
  logic [31:0] rf_wd;
  logic st_we;
  logic [MEM_AW-1:0] st_wa;
  logic [31:0] st_data;
  logic mem_we;
  logic [MEM_AW-1:0] mem_wa;
  logic [31:0] mem_wd;
  tceu_pkg::rsp_t res;

  assign in_acc    = req_valid && !req_stall;
  assign adv1      = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = clr_active || (s1_valid && !adv1);

  assign in_a = req.arg_a;
  assign in_b = req.arg_b;
  assign in_c = req.arg_c;

  // Three-register ops read b and c; everything else reads a and b.
  assign is_rrr = (req.command == tceu_pkg::CMD_EXEC) &&
                  ((req.opcode == tceu_pkg::OP_ADD) || (req.opcode == tceu_pkg::OP_SUB));
  assign ra1 = is_rrr ? in_b[REG_AW-1:0] : in_a[REG_AW-1:0];
  assign ra2 = is_rrr ? in_c[REG_AW-1:0] : in_b[REG_AW-1:0];
  assign mra = (req.command == tceu_pkg::CMD_READ_MEM) ? in_a[MEM_AW-1:0] : in_b[MEM_AW-1:0];

  // Register file RAM: two read ports, one write port.
  always_ff @(posedge clk) begin
    if (adv1 && rf_we) begin
      rf[rf_wa] <= rf_wd;
    end
    if (in_acc) begin
      rd1_q <= rf[ra1];
      rd2_q <= rf[ra2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld <= '0;
    end else if (adv1 && rf_we) begin
      rf_vld[rf_wa] <= 1'b1;
    end
  end

  // Data memory: one read port, one write port shared with the clearing pass.
  assign mem_we = clr_active || (adv1 && st_we);
  assign mem_wa = clr_active ? clr_addr : st_wa;
  assign mem_wd = clr_active ? 32'd0 : st_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dmem[mem_wa] <= mem_wd;
    end
    if (in_acc) begin
      mrd_q <= dmem[mra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == MEM_AW'(MEM_WORDS - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  // Capture the request and the forwarding decisions. The RAMs return the old word at
  // the edge where the item ahead writes, so a matching write is taken from here instead.
  logic [31:0] v1;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1        <= req;
      rd1_vld   <= rf_vld[ra1];
      rd2_vld   <= rf_vld[ra2];
      fwd1      <= adv1 && rf_we && (rf_wa == ra1);
      fwd2      <= adv1 && rf_we && (rf_wa == ra2);
      mfwd      <= adv1 && st_we && (st_wa == mra);
      rf_fwd_d  <= rf_wd;
      mem_fwd_d <= st_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (adv1) begin
      s1_valid <= 1'b0;
    end
  end

  // Execute stage.
  logic [31:0] v2, mv, ua, ub, uc, target;
  logic a_ok, b_ok, c_ok, mb_ok, ma_ok, ex, taken, halt_next;
  logic [1:0] st;
  logic signed [31:0] rv;
  logic [PC_BITS-1:0] pc_next;
  logic [31:0] pc_w;
  logic is_mem, is_br, is_alu;

  always_comb begin
    ua = s1.arg_a;
    ub = s1.arg_b;
    uc = s1.arg_c;
    v1 = fwd1 ? rf_fwd_d : (rd1_vld ? rd1_q : 32'd0);
    v2 = fwd2 ? rf_fwd_d : (rd2_vld ? rd2_q : 32'd0);
    mv = mfwd ? mem_fwd_d : mrd_q;
    a_ok  = ua < 32'(NUM_REGS);
    b_ok  = ub < 32'(NUM_REGS);
    c_ok  = uc < 32'(NUM_REGS);
    mb_ok = ub < 32'(MEM_WORDS);
    ma_ok = ua < 32'(MEM_WORDS);

    ex = s1_valid && (s1.command == tceu_pkg::CMD_EXEC) && !halt;

    rf_we     = 1'b0;
    rf_wa     = ua[REG_AW-1:0];
    rf_wd     = ub;
    st_we     = 1'b0;
    st_wa     = ub[MEM_AW-1:0];
    st_data   = v1;
    taken     = 1'b0;
    target    = ua;
    halt_next = halt;
    st        = tceu_pkg::ST_OK;
    rv        = '0;

    case (s1.command)
      tceu_pkg::CMD_EXEC: begin
        if (halt) begin
          st = tceu_pkg::ST_HALTED;
        end else begin
          case (s1.opcode)
            tceu_pkg::OP_LOAD: begin
              if (a_ok) rf_we = 1'b1; else st = tceu_pkg::ST_INVALID;
              rf_wd = ub;
            end
            tceu_pkg::OP_LOADM: begin
              if (a_ok && mb_ok) rf_we = 1'b1; else st = tceu_pkg::ST_INVALID;
              rf_wd = mv;
            end
            tceu_pkg::OP_ADD, tceu_pkg::OP_SUB: begin
              if (a_ok && b_ok && c_ok) rf_we = 1'b1; else st = tceu_pkg::ST_INVALID;
              rf_wd = (s1.opcode == tceu_pkg::OP_ADD) ? v1 + v2 : v1 - v2;
            end
            tceu_pkg::OP_ADDI, tceu_pkg::OP_SUBI: begin
              if (a_ok) rf_we = 1'b1; else st = tceu_pkg::ST_INVALID;
              rf_wd = (s1.opcode == tceu_pkg::OP_ADDI) ? v1 + ub : v1 - ub;
            end
            tceu_pkg::OP_STORE: begin
              if (a_ok && mb_ok) st_we = 1'b1; else st = tceu_pkg::ST_INVALID;
            end
            tceu_pkg::OP_MOV: begin
              if (a_ok && b_ok) rf_we = 1'b1; else st = tceu_pkg::ST_INVALID;
              rf_wd = v2;
            end
            tceu_pkg::OP_JMP: begin
              taken  = 1'b1;
              target = ua;
            end
            tceu_pkg::OP_BEQ, tceu_pkg::OP_BNE: begin
              target = uc;
              if (a_ok && b_ok) begin
                taken = ((s1.opcode == tceu_pkg::OP_BEQ) == (v1 == v2));
              end else begin
                st = tceu_pkg::ST_INVALID;
              end
            end
            tceu_pkg::OP_HALT: begin
              halt_next = 1'b1;
            end
            default: begin
              halt_next = 1'b1;
              st        = tceu_pkg::ST_UNKNOWN;
            end
          endcase
        end
      end
      tceu_pkg::CMD_READ_REG: begin
        if (a_ok) rv = v1; else st = tceu_pkg::ST_INVALID;
      end
      tceu_pkg::CMD_READ_MEM: begin
        if (ma_ok) rv = mv; else st = tceu_pkg::ST_INVALID;
      end
      default: begin
        st = tceu_pkg::ST_INVALID;
      end
    endcase

    rf_we = rf_we && ex;
    st_we = st_we && ex;

    if (!ex) begin
      pc_next = pc;
    end else if (taken) begin
      pc_next = target[PC_BITS-1:0];
    end else begin
      pc_next = pc + 1'b1;
    end
    pc_w = 32'(pc_next);

    is_mem = (s1.opcode == tceu_pkg::OP_LOAD) || (s1.opcode == tceu_pkg::OP_LOADM) ||
             (s1.opcode == tceu_pkg::OP_STORE);
    is_br  = (s1.opcode == tceu_pkg::OP_JMP) || (s1.opcode == tceu_pkg::OP_BEQ) ||
             (s1.opcode == tceu_pkg::OP_BNE);
    is_alu = (s1.opcode == tceu_pkg::OP_ADD) || (s1.opcode == tceu_pkg::OP_ADDI) ||
             (s1.opcode == tceu_pkg::OP_SUB) || (s1.opcode == tceu_pkg::OP_SUBI) ||
             (s1.opcode == tceu_pkg::OP_MOV);

    res.next_pc               = pc_w[15:0];
    res.halted                = ex ? halt_next : halt;
    res.status                = st;
    res.read_value            = rv;
    res.instructions_executed = cnt_insn + 32'(ex);
    if (is_mem) begin
      res.cycle_total = cnt_cycle + (ex ? tceu_pkg::CYC_MEM : 32'd0);
    end else if (is_br) begin
      res.cycle_total = cnt_cycle + (ex ? tceu_pkg::CYC_BRANCH : 32'd0);
    end else begin
      res.cycle_total = cnt_cycle + (ex ? tceu_pkg::CYC_OTHER : 32'd0);
    end
    res.alu_count    = cnt_alu + 32'(ex && is_alu);
    res.memory_count = cnt_mem + 32'(ex && is_mem);
    res.branch_count = cnt_br + 32'(ex && is_br);
    res.taken_count  = cnt_taken + 32'(ex && taken);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= '0;
      halt      <= 1'b0;
      cnt_insn  <= '0;
      cnt_cycle <= '0;
      cnt_alu   <= '0;
      cnt_mem   <= '0;
      cnt_br    <= '0;
      cnt_taken <= '0;
    end else if (adv1) begin
      pc        <= pc_next;
      halt      <= res.halted;
      cnt_insn  <= res.instructions_executed;
      cnt_cycle <= res.cycle_total;
      cnt_alu   <= res.alu_count;
      cnt_mem   <= res.memory_count;
      cnt_br    <= res.branch_count;
      cnt_taken <= res.taken_count;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (adv1) begin
      rsp <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv1) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

`include "toy_cpu_execute_unit_top_assert.svh"

  `TCEU_ASSERT_NOW(a_clear_idle, clr_active, !s1_valid, "request in flight during memory clear")
  `TCEU_ASSERT_NEXT(a_halt_sticky, halt, halt, "halt flag dropped without reset")
  `TCEU_ASSERT_NEXT(a_adv_shows, adv1, rsp_valid, "advanced item missing at output")
  `TCEU_ASSERT_NEXT(a_insn_step, adv1 && ex, cnt_insn == $past(cnt_insn) + 32'd1,
    "instruction counter did not step")

endmodule
